// ===== sv/psem_pkg.sv =====
// Shared types, register codes and constants of the power state energy meter.
package psem_pkg;

    localparam int TIME_W     = 32;
    localparam int VOLT_W     = 16;
    localparam int CURR_W     = 20;
    localparam int ENERGY_W   = 50;
    localparam int MUL_A_W    = 20;
    localparam int MUL_B_W    = 32;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = 54;
    localparam int PROD_W     = VOLT_W + SUM_W;
    localparam int NJ_DIV     = 1000000;
    localparam int REM_W      = 20;

    // The division by one million works on 16-bit digits of the padded voltage product.
    localparam int DIV_W      = 80;
    localparam int DIGIT_W    = 16;
    localparam int DIV_STEPS  = DIV_W / DIGIT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DIV_N_W    = REM_W + DIGIT_W;

    // One million is 64 times 15625; the reciprocal of 15625 is exact for 30-bit dividends.
    localparam int RECIP_PRE   = 6;
    localparam int RECIP_IN_W  = DIV_N_W - RECIP_PRE;
    localparam int RECIP_M_W   = 31;
    localparam int RECIP_P_W   = RECIP_IN_W + RECIP_M_W;
    localparam int RECIP_SHIFT = 44;
    localparam logic [RECIP_M_W-1:0] RECIP_M = 31'd1125899907;

    localparam int JOB_QUEUE_DEPTH = 2;

    localparam logic [VOLT_W-1:0] VOLT_RESET  = 16'd3300;
    localparam logic [CURR_W-1:0] IACT_RESET  = 20'd20000;
    localparam logic [CURR_W-1:0] ILIGHT_RESET = 20'd1000;
    localparam logic [CURR_W-1:0] IDEEP_RESET = 20'd10;

    localparam logic [2:0] MODE_CLEAR      = 3'd0;
    localparam logic [2:0] MODE_BEGIN      = 3'd1;
    localparam logic [2:0] MODE_END        = 3'd2;
    localparam logic [2:0] MODE_SLEEP      = 3'd3;
    localparam logic [2:0] MODE_CKPT_RESET = 3'd4;
    localparam logic [2:0] MODE_READ_CKPT  = 3'd5;
    localparam logic [2:0] MODE_READ_TOTAL = 3'd6;

    localparam logic [1:0] CFG_VOLTAGE  = 2'd0;
    localparam logic [1:0] CFG_I_ACTIVE = 2'd1;
    localparam logic [1:0] CFG_I_LIGHT  = 2'd2;
    localparam logic [1:0] CFG_I_DEEP   = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] now_us;
        logic              deep_sel;
        logic [TIME_W-1:0] sleep_us;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]   active_time_us;
        logic [TIME_W-1:0]   light_time_us;
        logic [TIME_W-1:0]   deep_time_us;
        logic [ENERGY_W-1:0] energy_nj;
        logic                nested_warning;
        logic                window_open;
    } result_t;

    typedef struct packed {
        logic              is_report;
        logic [TIME_W-1:0] ta;
        logic [TIME_W-1:0] tl;
        logic [TIME_W-1:0] td;
        logic              nested;
        logic              window_open;
    } job_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        index;
        logic [CURR_W-1:0] data;
    } cfg_write_t;

endpackage

// ===== sv/power_state_energy_meter.sv =====
// Top level of the power state energy meter.
// Event words are taken by the front end while its job queue has room, so a burst of events
// is accepted at one per cycle up to the queue depth. The back end takes each job; for a report
// word it then uses the one shared 20 x 32 multiplier for the three current products and both
// voltage halves, runs the division by one million, which finds five 16-bit quotient digits with
// one reciprocal multiplication each, and loads the result register. An event that reports
// nothing goes from taking the job straight to loading the result. A finished result waits
// in that register while the next job is worked on; a result that is not taken holds the back
// end, and once the queue fills the input is held as well.
// Configuration writes are always taken (ready is tied high) and must only be made while idle.
module power_state_energy_meter #(
    parameter int QUEUE_DEPTH = psem_pkg::JOB_QUEUE_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  psem_pkg::item_t             item,
    output logic                        empty,
    input  logic                        pop,
    output psem_pkg::result_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [psem_pkg::CURR_W-1:0] cfg_data
);
    import psem_pkg::*;

    job_t       front_job;
    logic       front_push;
    logic       queue_full;
    job_t       queue_job;
    logic       queue_empty;
    logic       queue_pop;
    cfg_write_t cfg;

    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    psem_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .job_push (front_push),
        .job_data (front_job),
        .job_full (queue_full)
    );

    psem_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_job),
        .full    (queue_full),
        .pop     (queue_pop),
        .rd_data (queue_job),
        .empty   (queue_empty)
    );

    psem_energy u_energy (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job       (queue_job),
        .job_empty (queue_empty),
        .job_pop   (queue_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

// ===== sv/psem_fifo.sv =====
// Short job queue between the event front end and the energy back end.
module psem_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psem_pkg::job_t wr_data,
    output logic           full,
    input  logic           pop,
    output psem_pkg::job_t rd_data,
    output logic           empty
);
    import psem_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== sv/psem_front.sv =====
// Event front end: takes event words, keeps the time counters and queues a job per event.
module psem_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  psem_pkg::item_t item,
    output logic            job_push,
    output psem_pkg::job_t  job_data,
    input  logic            job_full
);
    import psem_pkg::*;

    logic [TIME_W-1:0] ckpt_act_reg, ckpt_act_next;
    logic [TIME_W-1:0] ckpt_light_reg, ckpt_light_next;
    logic [TIME_W-1:0] ckpt_deep_reg, ckpt_deep_next;
    logic [TIME_W-1:0] mis_act_reg, mis_act_next;
    logic [TIME_W-1:0] mis_light_reg, mis_light_next;
    logic [TIME_W-1:0] mis_deep_reg, mis_deep_next;
    logic [TIME_W-1:0] win_start_reg, win_start_next;
    logic              win_flag_reg, win_flag_next;
    logic [TIME_W-1:0] elapsed;
    logic              accept;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign job_push = accept;
    assign elapsed  = item.now_us - win_start_reg;

    always_comb
    begin
        ckpt_act_next   = ckpt_act_reg;
        ckpt_light_next = ckpt_light_reg;
        ckpt_deep_next  = ckpt_deep_reg;
        mis_act_next    = mis_act_reg;
        mis_light_next  = mis_light_reg;
        mis_deep_next   = mis_deep_reg;
        win_start_next  = win_start_reg;
        win_flag_next   = win_flag_reg;
        job_data        = '0;

        unique case (item.mode)
            MODE_CLEAR:
            begin
                ckpt_act_next   = '0;
                ckpt_light_next = '0;
                ckpt_deep_next  = '0;
                mis_act_next    = '0;
                mis_light_next  = '0;
                mis_deep_next   = '0;
                win_start_next  = '0;
                win_flag_next   = 1'b0;
            end
            MODE_BEGIN:
            begin
                // A nested open keeps the first start time.
                if (win_flag_reg)
                begin
                    job_data.nested = 1'b1;
                end
                else
                begin
                    win_start_next = item.now_us;
                    win_flag_next  = 1'b1;
                end
            end
            MODE_END:
            begin
                if (win_flag_reg)
                begin
                    ckpt_act_next = ckpt_act_reg + elapsed;
                    mis_act_next  = mis_act_reg + elapsed;
                    win_flag_next = 1'b0;
                end
            end
            MODE_SLEEP:
            begin
                if (item.sleep_us != '0)
                begin
                    // An open window is paused: closed now, reopened when the sleep ends.
                    if (win_flag_reg)
                    begin
                        ckpt_act_next  = ckpt_act_reg + elapsed;
                        mis_act_next   = mis_act_reg + elapsed;
                        win_start_next = item.now_us + item.sleep_us;
                    end
                    if (item.deep_sel)
                    begin
                        ckpt_deep_next = ckpt_deep_reg + item.sleep_us;
                        mis_deep_next  = mis_deep_reg + item.sleep_us;
                    end
                    else
                    begin
                        ckpt_light_next = ckpt_light_reg + item.sleep_us;
                        mis_light_next  = mis_light_reg + item.sleep_us;
                    end
                end
            end
            MODE_CKPT_RESET:
            begin
                ckpt_act_next   = '0;
                ckpt_light_next = '0;
                ckpt_deep_next  = '0;
            end
            MODE_READ_CKPT:
            begin
                job_data.is_report = 1'b1;
                job_data.ta        = ckpt_act_reg;
                job_data.tl        = ckpt_light_reg;
                job_data.td        = ckpt_deep_reg;
            end
            MODE_READ_TOTAL:
            begin
                job_data.is_report = 1'b1;
                job_data.ta        = mis_act_reg;
                job_data.tl        = mis_light_reg;
                job_data.td        = mis_deep_reg;
            end
            default:
            begin
            end
        endcase

        job_data.window_open = win_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ckpt_act_reg   <= '0;
            ckpt_light_reg <= '0;
            ckpt_deep_reg  <= '0;
            mis_act_reg    <= '0;
            mis_light_reg  <= '0;
            mis_deep_reg   <= '0;
            win_start_reg  <= '0;
            win_flag_reg   <= 1'b0;
        end
        else if (accept)
        begin
            ckpt_act_reg   <= ckpt_act_next;
            ckpt_light_reg <= ckpt_light_next;
            ckpt_deep_reg  <= ckpt_deep_next;
            mis_act_reg    <= mis_act_next;
            mis_light_reg  <= mis_light_next;
            mis_deep_reg   <= mis_deep_next;
            win_start_reg  <= win_start_next;
            win_flag_reg   <= win_flag_next;
        end
    end

endmodule

// ===== sv/psem_energy.sv =====
// Energy back end: configuration registers, shared multiplier, digit divider and result register.
module psem_energy (
    input  logic                 clk,
    input  logic                 rst_n,
    input  psem_pkg::cfg_write_t cfg,
    input  psem_pkg::job_t       job,
    input  logic                 job_empty,
    output logic                 job_pop,
    output psem_pkg::result_t    result,
    output logic                 empty,
    input  logic                 pop
);
    import psem_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_ACC   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_DIGIT = 6'b010000,
        ST_DONE  = 6'b100000
    } eng_state_t;

    localparam logic [2:0] STEP_ACT   = 3'd0;
    localparam logic [2:0] STEP_LIGHT = 3'd1;
    localparam logic [2:0] STEP_DEEP  = 3'd2;
    localparam logic [2:0] STEP_V_LO  = 3'd3;
    localparam logic [2:0] STEP_V_HI  = 3'd4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    eng_state_t            state_reg, state_next;
    logic [VOLT_W-1:0]     volt_reg;
    logic [CURR_W-1:0]     i_act_reg, i_light_reg, i_deep_reg;
    job_t                  job_reg, job_next;
    logic [2:0]            step_reg, step_next;
    logic [MUL_P_W-1:0]    prod_reg, prod_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [DIV_W-1:0]      p_reg, p_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [RECIP_P_W-1:0]  recip_reg, recip_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [DIV_N_W-1:0]    div_num;
    logic [DIGIT_W-1:0]    digit;
    logic [DIV_N_W-1:0]    digit_back;
    logic                  pop_acc;
    logic                  load;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign pop_acc = pop && out_valid_reg;
    assign load    = (state_reg == ST_DONE) && (!out_valid_reg || pop_acc);
    assign job_pop = (state_reg == ST_IDLE) && !job_empty;

    // One shared 20 x 32 multiplier serves the three current products and both voltage halves.
    always_comb
    begin
        unique case (step_reg)
            STEP_ACT:
            begin
                mul_a = i_act_reg;
                mul_b = job_reg.ta;
            end
            STEP_LIGHT:
            begin
                mul_a = i_light_reg;
                mul_b = job_reg.tl;
            end
            STEP_DEEP:
            begin
                mul_a = i_deep_reg;
                mul_b = job_reg.td;
            end
            STEP_V_LO:
            begin
                mul_a = MUL_A_W'(volt_reg);
                mul_b = sum_reg[MUL_B_W-1:0];
            end
            default:
            begin
                mul_a = MUL_A_W'(volt_reg);
                mul_b = MUL_B_W'(sum_reg[SUM_W-1:MUL_B_W]);
            end
        endcase
    end

    // Long division by one million, one 16-bit digit at a time; the partial remainder stays
    // below one million, so each digit is found exactly by the reciprocal of 15625.
    assign div_num    = {rem_reg, p_reg[DIV_W-1:DIV_W-DIGIT_W]};
    assign digit      = recip_reg[RECIP_SHIFT+DIGIT_W-1:RECIP_SHIFT];
    assign digit_back = DIV_N_W'(digit) * DIV_N_W'(NJ_DIV);

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        recip_next     = recip_reg;
        div_cnt_next   = div_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (pop_acc)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_next  = job;
                    step_next = STEP_ACT;
                    sum_next  = '0;
                    state_next = job.is_report ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                prod_next  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (step_reg == STEP_V_LO)
                begin
                    p_next = DIV_W'(prod_reg);
                end
                else if (step_reg == STEP_V_HI)
                begin
                    // The upper voltage product is below 2^38, so it fits above bit 32.
                    p_next = p_reg + (DIV_W'(prod_reg[PROD_W-MUL_B_W-1:0]) << MUL_B_W);
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(prod_reg);
                end

                if (step_reg == STEP_V_HI)
                begin
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                recip_next = RECIP_P_W'(div_num[DIV_N_W-1:RECIP_PRE]) * RECIP_P_W'(RECIP_M);
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                rem_next     = REM_W'(div_num - digit_back);
                p_next       = {p_reg[DIV_W-DIGIT_W-1:0], digit};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    out_next.active_time_us = job_reg.ta;
                    out_next.light_time_us  = job_reg.tl;
                    out_next.deep_time_us   = job_reg.td;
                    out_next.energy_nj      = job_reg.is_report ? p_reg[ENERGY_W-1:0] : '0;
                    out_next.nested_warning = job_reg.nested;
                    out_next.window_open    = job_reg.window_open;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_ACT;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            volt_reg      <= VOLT_RESET;
            i_act_reg     <= IACT_RESET;
            i_light_reg   <= ILIGHT_RESET;
            i_deep_reg    <= IDEEP_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            div_cnt_reg   <= div_cnt_next;
            rem_reg       <= rem_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_VOLTAGE:  volt_reg    <= cfg.data[VOLT_W-1:0];
                    CFG_I_ACTIVE: i_act_reg   <= cfg.data;
                    CFG_I_LIGHT:  i_light_reg <= cfg.data;
                    CFG_I_DEEP:   i_deep_reg  <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        p_reg     <= p_next;
        recip_reg <= recip_next;
        out_reg   <= out_next;
    end

    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> !job_empty)
        else $error("job taken from an empty queue");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |=> (rem_reg < REM_W'(NJ_DIV)))
        else $error("divider remainder reached the divisor");

    a_div_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT && div_cnt_reg != DIV_LAST) |=> (state_reg == ST_DIV))
        else $error("division left before its last quotient digit");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !pop)
        |=> (state_reg == ST_DONE && out_valid_reg))
        else $error("result overwritten while the previous one waits");

endmodule
